/* design/bl3_pkg.sv */
// Package for the binary 3x3 lookup-table image filter.
// Holds the line size constants, register indexes and shared types; no dependencies.
`default_nettype none

package bl3_pkg;

  // Longest row that the line memory holds.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [COL_W-1:0] MAX_COL = COL_W'(MAX_WIDTH - 1);

  // Lookup table: eight 64-bit registers, 512 entries.
  localparam int TBL_REGS   = 8;
  localparam int TBL_REG_W  = 64;
  localparam int TBL_SIZE   = TBL_REGS * TBL_REG_W;
  localparam int TBL_IDX_W  = 9;
  localparam int CFG_ADDR_W = 3;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [TBL_REG_W-1:0]  cfg_data_t;
  typedef logic [TBL_IDX_W-1:0]  tbl_idx_t;
  typedef logic [COL_W-1:0]      col_t;

  // Register indexes, one per table slice.
  localparam cfg_addr_t REG_TBL_0_63    = 3'd0;
  localparam cfg_addr_t REG_TBL_64_127  = 3'd1;
  localparam cfg_addr_t REG_TBL_128_191 = 3'd2;
  localparam cfg_addr_t REG_TBL_192_255 = 3'd3;
  localparam cfg_addr_t REG_TBL_256_319 = 3'd4;
  localparam cfg_addr_t REG_TBL_320_383 = 3'd5;
  localparam cfg_addr_t REG_TBL_384_447 = 3'd6;
  localparam cfg_addr_t REG_TBL_448_511 = 3'd7;

  // One column of the line memory: the row two above and the row one above.
  typedef struct packed {
    logic upper;
    logic middle;
  } line_entry_t;

  // Answers of the lookup table.
  typedef struct packed {
    logic hit;         // entry at the window index
    logic entry_zero;  // entry 0, next background after a dark one
    logic entry_last;  // entry 511, next background after a lit one
  } lut_status_t;

endpackage

`default_nettype wire

/* design/bl3_in_if.sv */
// Input pixel channel of the filter: valid/ready with one raster pixel and its marks.
// No dependencies.
`default_nettype none

interface bl3_in_if;
  logic valid;
  logic ready;
  logic pixel_in;
  logic row_end;
  logic frame_end;

  modport source (output valid, output pixel_in, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input pixel_in, input row_end, input frame_end,
                output ready);
endinterface

`default_nettype wire

/* design/bl3_out_if.sv */
// Output pixel channel of the filter: valid/ready with one filtered pixel and its marks.
// No dependencies.
`default_nettype none

interface bl3_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic row_end_out;
  logic frame_end_out;

  modport source (output valid, output pixel_out, output row_end_out,
                  output frame_end_out, input ready);
  modport sink (input valid, input pixel_out, input row_end_out, input frame_end_out,
                output ready);
endinterface

`default_nettype wire

/* design/bl3_cfg_if.sv */
// Configuration write channel: valid/ready with a register index and 64-bit data.
// Depends on bl3_pkg for the index and data types.
`default_nettype none

interface bl3_cfg_if;
  import bl3_pkg::*;
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  cfg_data_t data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* design/binary_3x3_lut_image_filter_unit.sv */
// Binary 3x3 lookup-table image filter. Takes one raster pixel per clock and gives one
// filtered pixel per clock while the output is not stalled, the pixel centered one row up and
// one column left of it, with the row and frame end marks of the item that caused it; an
// accepted item waits in the lookup stage register and its result is loaded into the output
// register when that stage fires. The rate is set by the line memory, read at the item's column
// in the accept cycle and written back when the item leaves the lookup stage, with forwarding
// when two items in a row use the same column. Rows up to MAX_WIDTH pixels are held.
// Depends on bl3_pkg, the channel interfaces, bl3_line_buffer and bl3_lut.
`default_nettype none

module binary_3x3_lut_image_filter_unit (
  input wire logic clk,
  input wire logic rst,
  bl3_in_if.sink   src,
  bl3_out_if.source dst,
  bl3_cfg_if.sink  cfg
);
  import bl3_pkg::*;

  // Accept stage state.
  col_t       column_index;
  logic [1:0] rows_seen;
  logic       background_lit;
  logic       bg_next;

  // Lookup stage registers.
  logic       s1_valid;
  logic       s1_pix;
  logic       s1_rend;
  logic       s1_fend;
  logic [1:0] s1_rows;
  logic       s1_bg;
  logic       s1_bg_next;
  col_t       s1_addr;
  logic [5:0] window_columns;

  logic        in_fire;
  logic        s1_fire;
  line_entry_t rd_data;
  line_entry_t wr_data;
  logic        top;
  logic        mid;
  logic [2:0]  cur;
  logic [2:0]  far_col;
  logic [2:0]  near_col;
  tbl_idx_t    idx;
  lut_status_t lut;

  assign s1_fire   = s1_valid && (!dst.valid || dst.ready);
  assign src.ready = !s1_valid || s1_fire;
  assign in_fire   = src.valid && src.ready;

  assign bg_next = background_lit ? lut.entry_last : lut.entry_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index   <= '0;
      rows_seen      <= '0;
      background_lit <= 1'b0;
    end else if (in_fire) begin
      if (src.frame_end) begin
        background_lit <= bg_next;
        rows_seen      <= '0;
        column_index   <= '0;
      end else if (src.row_end) begin
        if (rows_seen < 2'd2) begin
          rows_seen <= rows_seen + 2'd1;
        end
        column_index <= '0;
      end else if (column_index < MAX_COL) begin
        column_index <= column_index + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix     <= src.pixel_in;
      s1_rend    <= src.row_end;
      s1_fend    <= src.frame_end;
      s1_rows    <= rows_seen;
      s1_bg      <= background_lit;
      s1_bg_next <= src.frame_end ? bg_next : background_lit;
      s1_addr    <= column_index;
    end
  end

  bl3_line_buffer u_line (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (column_index),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Rows not yet seen in this frame read the background.
  assign top      = (s1_rows >= 2'd2) ? rd_data.upper : s1_bg;
  assign mid      = (s1_rows >= 2'd1) ? rd_data.middle : s1_bg;
  assign cur      = {top, mid, s1_pix};
  assign far_col  = window_columns[5:3];
  assign near_col = window_columns[2:0];
  assign idx      = {far_col[2], near_col[2], cur[2],
                     far_col[1], near_col[1], cur[1],
                     far_col[0], near_col[0], cur[0]};

  assign wr_data.upper  = mid;
  assign wr_data.middle = s1_pix;

  bl3_lut u_lut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .idx    (idx),
    .status (lut)
  );

  // At a row start both earlier window columns take the background.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_columns <= '0;
    end else if (s1_fire) begin
      if (s1_rend || s1_fend) begin
        window_columns <= {6{s1_bg_next}};
      end else begin
        window_columns <= {near_col, cur};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (s1_fire) begin
      dst.valid <= 1'b1;
    end else if (dst.ready) begin
      dst.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      dst.pixel_out     <= lut.hit;
      dst.row_end_out   <= s1_rend;
      dst.frame_end_out <= s1_fend;
    end
  end

  // A stalled lookup stage keeps its item.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> s1_valid)
    else $error("lookup stage lost a stalled item");

  // A frame end restarts the frame counters for the next item.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && src.frame_end) |=> (rows_seen == 2'd0 && column_index == '0))
    else $error("frame counters not cleared after frame end");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    column_index <= MAX_COL)
    else $error("column index beyond line memory");

  a_rows_sat: assert property (@(posedge clk) disable iff (rst)
    rows_seen != 2'd3)
    else $error("row count passed saturation");

  // Every item leaving the lookup stage lands in the output register.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> dst.valid)
    else $error("result not presented after lookup");

endmodule

`default_nettype wire

/* design/bl3_line_buffer.sv */
// Line memory of the filter: one entry per column holding the two rows above.
// Synchronous read with registered data and write-to-read forwarding; uses bl3_pkg.
`default_nettype none

module bl3_line_buffer (
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire bl3_pkg::col_t       rd_addr,
  input  wire logic                wr_en,
  input  wire bl3_pkg::col_t       wr_addr,
  input  wire bl3_pkg::line_entry_t wr_data,
  output bl3_pkg::line_entry_t     rd_data
);
  import bl3_pkg::*;

  line_entry_t mem [MAX_WIDTH];

  // A read of the column written at the same edge returns the new entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

/* design/bl3_lut.sv */
// Lookup table of the filter: eight 64-bit configuration registers and the read mux.
// Depends on bl3_pkg and bl3_cfg_if.
`default_nettype none

module bl3_lut (
  input  wire logic           clk,
  input  wire logic           rst,
  bl3_cfg_if.sink             cfg,
  input  wire bl3_pkg::tbl_idx_t idx,
  output bl3_pkg::lut_status_t   status
);
  import bl3_pkg::*;

  cfg_data_t           table_regs [TBL_REGS];
  logic [TBL_SIZE-1:0] table_flat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TBL_REGS; k++) begin
        table_regs[k] <= '0;
      end
    end else if (cfg.valid) begin
      table_regs[cfg.addr] <= cfg.data;
    end
  end

  always_comb begin
    for (int k = 0; k < TBL_REGS; k++) begin
      table_flat[k*TBL_REG_W +: TBL_REG_W] = table_regs[k];
    end
  end

  assign status.hit        = table_flat[idx];
  assign status.entry_zero = table_flat[0];
  assign status.entry_last = table_flat[TBL_SIZE-1];

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for binary_3x3_lut_image_filter_unit: streams binary raster frames,
// predicts every filtered pixel in-bench and checks each result in order.
// Depends on bl3_pkg, the three channel interfaces and the filter top level.

module tb_top;
  import bl3_pkg::*;

  typedef struct packed {
    logic pixel;
    logic row_end;
    logic frame_end;
  } filt_pixel_t;

  typedef enum int {PACE_STEADY, PACE_LIGHT, PACE_HEAVY} pace_t;

  localparam cfg_addr_t TABLE_SLICE [TBL_REGS] = '{
    REG_TBL_0_63, REG_TBL_64_127, REG_TBL_128_191, REG_TBL_192_255,
    REG_TBL_256_319, REG_TBL_320_383, REG_TBL_384_447, REG_TBL_448_511
  };
  localparam int LINGER_CYCLES = 8;
  localparam int PHASE_PIXELS  = 100;

  logic clk;
  logic rst;

  bl3_in_if  pix_if ();
  bl3_out_if res_if ();
  bl3_cfg_if cfg_if ();

  binary_3x3_lut_image_filter_unit DUT (
    .clk (clk),
    .rst (rst),
    .src (pix_if),
    .dst (res_if),
    .cfg (cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Filter state as the bench sees it.
  cfg_data_t lut_regs [TBL_REGS];
  cfg_data_t table_plan [TBL_REGS];
  logic      upper_mem [MAX_WIDTH];
  logic      middle_mem [MAX_WIDTH];
  logic [5:0] win_cols;
  col_t       col_idx;
  logic [1:0] rows_done;
  logic       bg_lit;
  int         cols_written;

  filt_pixel_t expected_pixels [$];

  int    errors;
  int    pixels_sent;
  int    results_checked;
  int    frames_sent;
  int    table_writes;
  int    lit_frames;
  pace_t send_pace;
  pace_t recv_pace;

  function automatic logic lut_entry(input tbl_idx_t idx);
    return lut_regs[idx[8:6]][idx[5:0]];
  endfunction

  function automatic int draw_wait(input pace_t pace);
    case (pace)
      PACE_STEADY: return 0;
      PACE_LIGHT: return ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 17)) : 0;
      default: return int'($urandom_range(0, 17));
    endcase
  endfunction

  // Computes the filtered pixel for one accepted item and advances the line state.
  task automatic predict_pixel(input logic pix, input logic rend, input logic fend);
    logic top;
    logic mid;
    logic [2:0] cur;
    logic [2:0] far_col;
    logic [2:0] near_col;
    tbl_idx_t idx;
    filt_pixel_t res;
    top = (rows_done >= 2) ? upper_mem[col_idx] : bg_lit;
    mid = (rows_done >= 1) ? middle_mem[col_idx] : bg_lit;
    cur = {top, mid, pix};
    far_col = win_cols[5:3];
    near_col = win_cols[2:0];
    idx = {far_col[2], near_col[2], cur[2], far_col[1], near_col[1], cur[1],
           far_col[0], near_col[0], cur[0]};
    res.pixel = lut_entry(idx);
    res.row_end = rend;
    res.frame_end = fend;
    expected_pixels.push_back(res);

    upper_mem[col_idx] = mid;
    middle_mem[col_idx] = pix;
    if (int'(col_idx) >= cols_written) cols_written = int'(col_idx) + 1;
    win_cols = {near_col, cur};

    if (fend) begin
      if (bg_lit) lit_frames++;
      bg_lit = bg_lit ? lut_entry(tbl_idx_t'(TBL_SIZE - 1)) : lut_entry('0);
      rows_done = '0;
      col_idx = '0;
      win_cols = {6{bg_lit}};
      frames_sent++;
    end else if (rend) begin
      if (rows_done < 2) rows_done = rows_done + 2'd1;
      col_idx = '0;
      win_cols = {6{bg_lit}};
    end else if (col_idx != MAX_COL) begin
      col_idx = col_idx + 1'b1;
    end
  endtask

  task automatic send_pixel(input logic pix, input logic rend, input logic fend);
    int gap;
    if (pixels_sent % 40 == 0) send_pace = pace_t'($urandom_range(0, 2));
    gap = draw_wait(send_pace);
    repeat (gap) begin
      @(negedge clk);
      pix_if.valid = 1'b0;
    end
    @(negedge clk);
    pix_if.valid = 1'b1;
    pix_if.pixel_in = pix;
    pix_if.row_end = rend;
    pix_if.frame_end = fend;
    do @(posedge clk); while (!pix_if.ready);
    predict_pixel(pix, rend, fend);
    pixels_sent++;
  endtask

  // Sends len pixels of pat, most significant first; the marks go on the last one.
  task automatic send_pattern(input logic [15:0] pat, input int len, input logic rend,
                              input logic fend);
    for (int i = len - 1; i >= 0; i--)
      send_pixel(pat[i], (i == 0) && rend, (i == 0) && fend);
  endtask

  // Random row; density is the lit share in quarters.
  task automatic send_row(input int len, input int density, input logic last_row,
                          input logic fend_rend);
    logic pix;
    logic at_end;
    for (int i = 0; i < len; i++) begin
      pix = ($urandom_range(0, 3) < density);
      at_end = (i == len - 1);
      send_pixel(pix, at_end && (!last_row || fend_rend), at_end && last_row);
    end
  endtask

  task automatic send_frame(input int max_len);
    int rows;
    int len;
    int density;
    logic fend_rend;
    rows = $urandom_range(1, 6);
    density = $urandom_range(0, 4);
    fend_rend = 1'($urandom_range(0, 1));
    for (int r = 0; r < rows; r++) begin
      len = $urandom_range(1, max_len);
      // A row below the first must stay within columns already held in the line memory.
      if (rows_done >= 1 && int'(col_idx) + len > cols_written)
        len = cols_written - int'(col_idx);
      send_row(len, density, r == rows - 1, fend_rend);
    end
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                 $urandom_range(0, 7) == 0);
  endtask

  task automatic wait_drained;
    @(negedge clk);
    pix_if.valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic plan_random_table(input logic entry_zero, input logic entry_last);
    for (int k = 0; k < TBL_REGS; k++) table_plan[k] = {$urandom, $urandom};
    table_plan[0][0] = entry_zero;
    table_plan[TBL_REGS-1][TBL_REG_W-1] = entry_last;
  endtask

  task automatic plan_constant_table(input logic value);
    for (int k = 0; k < TBL_REGS; k++) table_plan[k] = {TBL_REG_W{value}};
  endtask

  task automatic write_table;
    wait_drained();
    for (int k = 0; k < TBL_REGS; k++) begin
      @(negedge clk);
      cfg_if.valid = 1'b1;
      cfg_if.addr = TABLE_SLICE[k];
      cfg_if.data = table_plan[k];
      do @(posedge clk); while (!cfg_if.ready);
      lut_regs[TABLE_SLICE[k]] = table_plan[k];
      table_writes++;
    end
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Small frames: reset table, short and long rows, frame end alone and with row end,
  // and both background flips.
  task automatic test_directed;
    send_pattern(16'b10, 2, 1'b1, 1'b0);
    send_pattern(16'b01, 2, 1'b1, 1'b1);
    plan_random_table(1'b1, 1'b0);
    write_table();
    send_pattern(16'b1110, 4, 1'b1, 1'b0);
    send_pattern(16'b0101, 4, 1'b1, 1'b0);
    send_pattern(16'b11, 2, 1'b1, 1'b0);
    // Last row reads stale line entries past the short row and ends on frame end only.
    send_pattern(16'b1011, 4, 1'b0, 1'b1);
    send_pattern(16'b101, 3, 1'b1, 1'b1);
    send_pattern(16'b1, 1, 1'b1, 1'b1);
    send_pattern(16'b0, 1, 1'b0, 1'b1);
  endtask

  // One row past the line memory, so the last column saturates and every entry is written.
  task automatic test_long_row;
    plan_random_table(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    write_table();
    send_row(MAX_WIDTH + 6, 2, 1'b0, 1'b0);
    send_row(12, 2, 1'b1, 1'b1);
  endtask

  task automatic test_table_extremes;
    plan_constant_table(1'b0);
    write_table();
    repeat (4) send_frame(12);
    plan_constant_table(1'b1);
    write_table();
    repeat (4) send_frame(12);
  endtask

  task automatic test_random_streams;
    int target;
    for (int phase = 0; phase < 5; phase++) begin
      plan_random_table(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      write_table();
      target = pixels_sent + PHASE_PIXELS;
      while (pixels_sent < target) begin
        if ($urandom_range(0, 7) == 0) send_noise($urandom_range(3, 12));
        else if ($urandom_range(0, 9) == 0) send_frame(3);
        else send_frame(24);
        // Let the output side empty now and then with the input held off.
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end
  endtask

  // Result side: random stalls per item.
  initial begin
    int gap;
    int got;
    res_if.ready = 1'b0;
    got = 0;
    recv_pace = PACE_STEADY;
    forever begin
      if (got % 40 == 0) recv_pace = pace_t'($urandom_range(0, 2));
      gap = draw_wait(recv_pace);
      repeat (gap) begin
        @(negedge clk);
        res_if.ready = 1'b0;
      end
      @(negedge clk);
      res_if.ready = 1'b1;
      do @(posedge clk); while (!res_if.valid);
      got++;
    end
  end

  always @(posedge clk) begin
    filt_pixel_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with nothing expected: pixel %0b row_end %0b frame_end %0b",
                 $time, res_if.pixel_out, res_if.row_end_out, res_if.frame_end_out);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (res_if.pixel_out !== want.pixel) begin
          $display("%0t: pixel_out expected %0b got %0b", $time, want.pixel,
                   res_if.pixel_out);
          errors++;
        end
        if (res_if.row_end_out !== want.row_end) begin
          $display("%0t: row_end_out expected %0b got %0b", $time, want.row_end,
                   res_if.row_end_out);
          errors++;
        end
        if (res_if.frame_end_out !== want.frame_end) begin
          $display("%0t: frame_end_out expected %0b got %0b", $time, want.frame_end,
                   res_if.frame_end_out);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("binary_3x3_lut_image_filter_unit verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    pix_if.valid = 1'b0;
    pix_if.pixel_in = 1'b0;
    pix_if.row_end = 1'b0;
    pix_if.frame_end = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = REG_TBL_0_63;
    cfg_if.data = '0;
    for (int k = 0; k < TBL_REGS; k++) lut_regs[k] = '0;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      upper_mem[c] = 1'b0;
      middle_mem[c] = 1'b0;
    end
    win_cols = '0;
    col_idx = '0;
    rows_done = '0;
    bg_lit = 1'b0;
    cols_written = 0;
    errors = 0;
    pixels_sent = 0;
    results_checked = 0;
    frames_sent = 0;
    table_writes = 0;
    lit_frames = 0;
    send_pace = PACE_STEADY;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_long_row();
    test_table_extremes();
    test_random_streams();

    wait_drained();
    repeat (LINGER_CYCLES) @(posedge clk);

    $display("Streamed %0d pixels in %0d frames (%0d on a lit background), %0d results checked.",
             pixels_sent, frames_sent, lit_frames, results_checked);
    $display("Table loaded through %0d register writes, including all-dark and all-lit tables.",
             table_writes);
    if (errors == 0) begin
      $display("binary_3x3_lut_image_filter_unit verification clean");
    end else begin
      $display("binary_3x3_lut_image_filter_unit verification failed");
    end
    $finish;
  end

endmodule
